[design/assert_macros.svh]
// Assertion helpers included by the frame receiver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property at every rising edge of the clock outside reset.
`define ASSERT_AT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) else $error(msg);

// Checks that an expression is never true outside reset.
`define ASSERT_NEVER(lbl, ck, rs, expr, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(expr)) else $error(msg);

`else

`define ASSERT_AT(lbl, ck, rs, prop, msg)
`define ASSERT_NEVER(lbl, ck, rs, expr, msg)

`endif

`endif

[design/bsfr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bsfr_pkg;

  localparam int MAX_STORE_DEF = 1024;

  localparam int BYTE_W   = 8;
  localparam int LIMIT_W  = 11;
  localparam int CRC_W    = 16;
  localparam int INDEX_W  = 10;
  localparam int LENGTH_W = 11;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

  localparam logic [BYTE_W-1:0]  BEGIN_SYNC_RST     = 8'hAA;
  localparam logic [BYTE_W-1:0]  END_SYNC_RST       = 8'h55;
  localparam logic [LIMIT_W-1:0] STORE_LIMIT_RST    = 11'd1024;
  localparam logic [CRC_W-1:0]   CRC_SEED_RST       = 16'hFFFF;
  localparam logic [CRC_W-1:0]   CRC_FINAL_XOR_RST  = 16'h0000;
  localparam logic               CRC_HIGH_FIRST_RST = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BEGIN_SYNC     = 3'd0,
    REG_END_SYNC       = 3'd1,
    REG_STORE_LIMIT    = 3'd2,
    REG_CRC_SEED       = 3'd3,
    REG_CRC_FINAL_XOR  = 3'd4,
    REG_CRC_HIGH_FIRST = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_GOOD     = 3'd1,
    EV_BAD_CRC  = 3'd2,
    EV_EMPTY    = 3'd3,
    EV_OVERFLOW = 3'd4
  } event_t;

  // One byte through the MSB-first CRC-16 register, unrolled over its eight bits.
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[design/byte_stuffed_frame_receiver_crc16.sv]
// Byte-stuffed frame receiver with CRC-16 check. Each input beat carries one line byte and
// yields exactly one result beat. A doubled begin sync opens a frame, the first data byte
// is the command code, a single sync followed by any other byte stands for the sync value,
// and a doubled end sync gives a good, bad-CRC or empty report and the payload length,
// closing the frame unless the report is empty; the last two stored bytes are the
// received CRC. Every stored byte is reported with its index. The block takes one byte
// per clock cycle, and each result appears in the cycle after its byte is taken: the
// frame state and one unrolled CRC byte step are updated together, and a result register
// holds the report so that a new byte is taken whenever that register is empty or being
// read in the same cycle. Configuration registers are written through the always-ready cfg port.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module byte_stuffed_frame_receiver_crc16 #(
  parameter int MAX_STORE = bsfr_pkg::MAX_STORE_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [bsfr_pkg::BYTE_W-1:0]       rx_byte,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [2:0]                             event_res,
  output logic                                   restarted,
  output logic                                   data_valid,
  output logic [bsfr_pkg::BYTE_W-1:0]            data_byte,
  output logic [bsfr_pkg::INDEX_W-1:0]           data_index,
  output logic [bsfr_pkg::BYTE_W-1:0]            frame_cmd,
  output logic [bsfr_pkg::LENGTH_W-1:0]          frame_length,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bsfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bsfr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW = $clog2(MAX_STORE + 1);
  localparam int LW = (CW > bsfr_pkg::LIMIT_W) ? CW : bsfr_pkg::LIMIT_W;
  localparam logic [LW-1:0] MAX_STORE_LW = LW'(MAX_STORE);

  logic [bsfr_pkg::BYTE_W-1:0]  begin_sync;
  logic [bsfr_pkg::BYTE_W-1:0]  end_sync;
  logic [bsfr_pkg::LIMIT_W-1:0] store_limit;
  logic [bsfr_pkg::CRC_W-1:0]   crc_seed;
  logic [bsfr_pkg::CRC_W-1:0]   crc_final_xor;
  logic                         crc_high_first;

  logic                         begin_seen, begin_seen_next;
  logic                         end_seen, end_seen_next;
  logic                         in_frame, in_frame_next;
  logic                         have_code, have_code_next;
  logic [bsfr_pkg::BYTE_W-1:0]  code_reg, code_reg_next;
  logic [CW-1:0]                stored_count, stored_count_next;
  logic [bsfr_pkg::CRC_W-1:0]   crc_reg, crc_reg_next;
  logic [bsfr_pkg::BYTE_W-1:0]  recent [0:2];
  logic [bsfr_pkg::BYTE_W-1:0]  recent_next [0:2];

  bsfr_pkg::event_t             ev;
  logic                         rs;
  logic                         dv;
  logic [bsfr_pkg::BYTE_W-1:0]  dbyte;
  logic [LW-1:0]                dindex;
  logic [LW-1:0]                flen;
  logic [LW-1:0]                limit;
  logic [bsfr_pkg::CRC_W-1:0]   rx_crc;
  logic [bsfr_pkg::CRC_W-1:0]   crc_fin;
  logic [bsfr_pkg::BYTE_W-1:0]  v;
  logic                         accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      begin_sync     <= bsfr_pkg::BEGIN_SYNC_RST;
      end_sync       <= bsfr_pkg::END_SYNC_RST;
      store_limit    <= bsfr_pkg::STORE_LIMIT_RST;
      crc_seed       <= bsfr_pkg::CRC_SEED_RST;
      crc_final_xor  <= bsfr_pkg::CRC_FINAL_XOR_RST;
      crc_high_first <= bsfr_pkg::CRC_HIGH_FIRST_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bsfr_pkg::REG_BEGIN_SYNC:     begin_sync     <= cfg_data[bsfr_pkg::BYTE_W-1:0];
        bsfr_pkg::REG_END_SYNC:       end_sync       <= cfg_data[bsfr_pkg::BYTE_W-1:0];
        bsfr_pkg::REG_STORE_LIMIT:    store_limit    <= cfg_data[bsfr_pkg::LIMIT_W-1:0];
        bsfr_pkg::REG_CRC_SEED:       crc_seed       <= cfg_data;
        bsfr_pkg::REG_CRC_FINAL_XOR:  crc_final_xor  <= cfg_data;
        bsfr_pkg::REG_CRC_HIGH_FIRST: crc_high_first <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    limit = (LW'(store_limit) < MAX_STORE_LW) ? LW'(store_limit) : MAX_STORE_LW;

    begin_seen_next   = begin_seen;
    end_seen_next     = end_seen;
    in_frame_next     = in_frame;
    have_code_next    = have_code;
    code_reg_next     = code_reg;
    stored_count_next = stored_count;
    crc_reg_next      = crc_reg;
    for (int i = 0; i < 3; i++) begin
      recent_next[i] = recent[i];
    end

    ev      = bsfr_pkg::EV_NONE;
    rs      = 1'b0;
    dv      = 1'b0;
    dbyte   = '0;
    dindex  = '0;
    flen    = '0;
    v       = rx_byte;
    crc_fin = crc_reg ^ crc_final_xor;
    rx_crc  = crc_high_first ? {recent[1], recent[0]} : {recent[0], recent[1]};

    if (rx_byte == begin_sync) begin
      if (begin_seen) begin
        rs                = in_frame;
        crc_reg_next      = crc_seed;
        begin_seen_next   = 1'b0;
        end_seen_next     = 1'b0;
        in_frame_next     = 1'b1;
        have_code_next    = 1'b0;
        code_reg_next     = '0;
        stored_count_next = '0;
        for (int i = 0; i < 3; i++) begin
          recent_next[i] = '0;
        end
      end else begin
        begin_seen_next = 1'b1;
      end
    end else if (rx_byte == end_sync) begin
      if (end_seen) begin
        if (in_frame) begin
          if (stored_count >= CW'(3)) begin
            stored_count_next = stored_count - CW'(2);
            crc_reg_next      = crc_fin;
            in_frame_next     = 1'b0;
            ev   = (crc_fin == rx_crc) ? bsfr_pkg::EV_GOOD : bsfr_pkg::EV_BAD_CRC;
            flen = LW'(stored_count - CW'(2));
          end else begin
            ev   = bsfr_pkg::EV_EMPTY;
            flen = LW'(stored_count);
          end
        end
      end else begin
        end_seen_next = 1'b1;
      end
    end else if (in_frame) begin
      if (LW'(stored_count) < limit) begin
        if (!have_code) begin
          code_reg_next  = rx_byte;
          have_code_next = 1'b1;
          crc_reg_next   = bsfr_pkg::crc_byte(crc_reg, rx_byte);
        end else begin
          if (end_seen) begin
            v               = end_sync;
            end_seen_next   = 1'b0;
            begin_seen_next = 1'b0;
          end else if (begin_seen) begin
            v               = begin_sync;
            begin_seen_next = 1'b0;
          end
          recent_next[2]    = recent[1];
          recent_next[1]    = recent[0];
          recent_next[0]    = v;
          dv                = 1'b1;
          dbyte             = v;
          dindex            = LW'(stored_count);
          stored_count_next = stored_count + CW'(1);
          if (stored_count >= CW'(2)) begin
            crc_reg_next = bsfr_pkg::crc_byte(crc_reg, recent[1]);
          end
        end
      end else begin
        ev = bsfr_pkg::EV_OVERFLOW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      begin_seen   <= 1'b0;
      end_seen     <= 1'b0;
      in_frame     <= 1'b0;
      have_code    <= 1'b0;
      code_reg     <= '0;
      stored_count <= '0;
      crc_reg      <= bsfr_pkg::CRC_SEED_RST;
      for (int i = 0; i < 3; i++) begin
        recent[i] <= '0;
      end
    end else if (accept) begin
      begin_seen   <= begin_seen_next;
      end_seen     <= end_seen_next;
      in_frame     <= in_frame_next;
      have_code    <= have_code_next;
      code_reg     <= code_reg_next;
      stored_count <= stored_count_next;
      crc_reg      <= crc_reg_next;
      for (int i = 0; i < 3; i++) begin
        recent[i] <= recent_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      event_res    <= ev;
      restarted    <= rs;
      data_valid   <= dv;
      data_byte    <= dbyte;
      data_index   <= dindex[bsfr_pkg::INDEX_W-1:0];
      frame_cmd    <= code_reg_next;
      frame_length <= flen[bsfr_pkg::LENGTH_W-1:0];
    end
  end

  `ASSERT_AT(a_count_bound, clk, rst, LW'(stored_count) <= MAX_STORE_LW, "stored count above maximum")
  `ASSERT_NEVER(a_data_with_event, clk, rst, out_valid && data_valid && (event_res != bsfr_pkg::EV_NONE), "stored byte reported with an event")
  `ASSERT_NEVER(a_restart_alone, clk, rst, out_valid && restarted && (data_valid || (event_res != bsfr_pkg::EV_NONE)), "restart reported with data or event")
  `ASSERT_AT(a_close_ends_frame, clk, rst, accept && ((ev == bsfr_pkg::EV_GOOD) || (ev == bsfr_pkg::EV_BAD_CRC)) |=> !in_frame, "frame still open after close")

endmodule

`default_nettype wire

[tb/byte_stuffed_frame_receiver_crc16_test.sv]
`timescale 1ns / 1ps

module byte_stuffed_frame_receiver_crc16_test;

  localparam int STORE_MAX = bsfr_pkg::MAX_STORE_DEF;
  localparam int LONG_CAP = 256;

  typedef struct packed {
    bsfr_pkg::event_t ev;
    logic        restart;
    logic        stored;
    logic [7:0]  value;
    logic [9:0]  pos;
    logic [7:0]  code;
    logic [10:0] length;
  } rx_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  event_res;
  logic        restarted;
  logic        data_valid;
  logic [7:0]  data_byte;
  logic [9:0]  data_index;
  logic [7:0]  frame_cmd;
  logic [10:0] frame_length;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  bsfr_pkg::cfg_reg_t cfg_index = bsfr_pkg::REG_BEGIN_SYNC;
  logic [15:0] cfg_data = 16'h0000;

  byte_stuffed_frame_receiver_crc16 dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .event_res(event_res),
    .restarted(restarted),
    .data_valid(data_valid),
    .data_byte(data_byte),
    .data_index(data_index),
    .frame_cmd(frame_cmd),
    .frame_length(frame_length),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register copies held by the predictor.
  logic [7:0]  sync_begin;
  logic [7:0]  sync_end;
  logic [10:0] store_cap;
  logic [15:0] seed_value;
  logic [15:0] final_xor;
  logic        high_first;

  // Frame state held by the predictor.
  logic        begin_mark;
  logic        end_mark;
  logic        frame_open;
  logic        code_taken;
  logic [7:0]  cmd_code;
  logic [10:0] stored_n;
  logic [15:0] crc_acc;
  logic [7:0]  recent [3];

  logic [7:0]  line_bytes [$];
  rx_report_t  pending_reports [$];

  bit          byte_taken;
  int          gap_left;
  int          burst_left;
  bit          hold_request;
  int          hold_left;
  logic [15:0] ready_pattern;
  logic [3:0]  pattern_pos;

  int unsigned errors;
  int unsigned report_count;
  int unsigned settings_loaded;
  int unsigned n_good, n_bad, n_empty, n_overflow, n_restart, n_stored;

  function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ d[i];
      c = {c[14:0], 1'b0} ^ (fb ? bsfr_pkg::CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic void clear_frame();
    crc_acc = seed_value;
    begin_mark = 1'b0;
    end_mark = 1'b0;
    frame_open = 1'b0;
    code_taken = 1'b0;
    cmd_code = 8'h00;
    stored_n = 11'd0;
    recent[0] = 8'h00;
    recent[1] = 8'h00;
    recent[2] = 8'h00;
  endfunction

  function automatic rx_report_t frame_step(input logic [7:0] b);
    rx_report_t r;
    logic [10:0] cap;
    logic [7:0] v;
    logic [15:0] rx_crc;
    r = '0;
    cap = (store_cap < 11'(STORE_MAX)) ? store_cap : 11'(STORE_MAX);
    if (b == sync_begin) begin
      if (begin_mark) begin
        r.restart = frame_open;
        clear_frame();
        frame_open = 1'b1;
      end else begin
        begin_mark = 1'b1;
      end
    end else if (b == sync_end) begin
      if (end_mark) begin
        if (frame_open) begin
          if (stored_n >= 3) begin
            rx_crc = high_first ? {recent[1], recent[0]} : {recent[0], recent[1]};
            stored_n = stored_n - 11'd2;
            crc_acc = crc_acc ^ final_xor;
            frame_open = 1'b0;
            r.ev = (crc_acc == rx_crc) ? bsfr_pkg::EV_GOOD : bsfr_pkg::EV_BAD_CRC;
          end else begin
            r.ev = bsfr_pkg::EV_EMPTY;
          end
          r.length = stored_n;
        end
      end else begin
        end_mark = 1'b1;
      end
    end else if (frame_open) begin
      if (stored_n < cap) begin
        if (!code_taken) begin
          cmd_code = b;
          code_taken = 1'b1;
          crc_acc = crc16_update(crc_acc, b);
        end else begin
          v = b;
          if (end_mark) begin
            v = sync_end;
            end_mark = 1'b0;
            begin_mark = 1'b0;
          end else if (begin_mark) begin
            v = sync_begin;
            begin_mark = 1'b0;
          end
          recent[2] = recent[1];
          recent[1] = recent[0];
          recent[0] = v;
          r.stored = 1'b1;
          r.value = v;
          r.pos = stored_n[9:0];
          stored_n = stored_n + 11'd1;
        end
        if (stored_n > 2) begin
          crc_acc = crc16_update(crc_acc, recent[2]);
        end
      end else begin
        r.ev = bsfr_pkg::EV_OVERFLOW;
      end
    end
    r.code = cmd_code;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Sender: bursts of beats separated by random gaps.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || byte_taken) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (line_bytes.size() != 0) begin
        in_valid <= 1'b1;
        rx_byte <= line_bytes.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: steps through a fresh 16-bit ready pattern at a time, or one long hold-off on request.
  always @(negedge clk) begin : receiver
    logic [15:0] fresh;
    if (rst) begin
      out_ready <= 1'b0;
      pattern_pos <= 4'd0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request) begin
      hold_request <= 1'b0;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else begin
      if (pattern_pos == 4'd0) begin
        case ($urandom_range(0, 3))
          0: fresh = 16'hFFFF;
          1: fresh = $urandom;
          2: fresh = $urandom | $urandom;
          default: fresh = $urandom & $urandom;
        endcase
        ready_pattern <= fresh;
        out_ready <= fresh[0];
      end else begin
        out_ready <= ready_pattern[pattern_pos];
      end
      pattern_pos <= pattern_pos + 4'd1;
    end
  end

  always @(posedge clk) begin : monitor
    rx_report_t want;
    byte_taken = !rst && in_valid && in_ready;
    if (byte_taken) begin
      pending_reports.push_back(frame_step(rx_byte));
    end
    if (!rst && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: result beat with nothing expected", $time);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        report_count++;
        check_field("event_res", want.ev, event_res);
        check_field("restarted", want.restart, restarted);
        check_field("data_valid", want.stored, data_valid);
        check_field("data_byte", want.value, data_byte);
        check_field("data_index", want.pos, data_index);
        check_field("frame_cmd", want.code, frame_cmd);
        check_field("frame_length", want.length, frame_length);
        case (want.ev)
          bsfr_pkg::EV_GOOD: n_good++;
          bsfr_pkg::EV_BAD_CRC: n_bad++;
          bsfr_pkg::EV_EMPTY: n_empty++;
          bsfr_pkg::EV_OVERFLOW: n_overflow++;
          default: ;
        endcase
        n_restart += want.restart;
        n_stored += want.stored;
      end
    end
  end

  task automatic write_reg(input bsfr_pkg::cfg_reg_t r, input logic [15:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = r;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    case (r)
      bsfr_pkg::REG_BEGIN_SYNC: sync_begin = v[7:0];
      bsfr_pkg::REG_END_SYNC: sync_end = v[7:0];
      bsfr_pkg::REG_STORE_LIMIT: store_cap = v[10:0];
      bsfr_pkg::REG_CRC_SEED: seed_value = v;
      bsfr_pkg::REG_CRC_FINAL_XOR: final_xor = v;
      bsfr_pkg::REG_CRC_HIGH_FIRST: high_first = v[0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [7:0] b, input logic [7:0] e,
                               input logic [10:0] lim, input logic [15:0] seed,
                               input logic [15:0] xr, input logic hf);
    write_reg(bsfr_pkg::REG_BEGIN_SYNC, {8'h00, b});
    write_reg(bsfr_pkg::REG_END_SYNC, {8'h00, e});
    write_reg(bsfr_pkg::REG_STORE_LIMIT, {5'd0, lim});
    write_reg(bsfr_pkg::REG_CRC_SEED, seed);
    write_reg(bsfr_pkg::REG_CRC_FINAL_XOR, xr);
    write_reg(bsfr_pkg::REG_CRC_HIGH_FIRST, {15'd0, hf});
    @(negedge clk);
    cfg_valid = 1'b0;
    settings_loaded++;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (line_bytes.size() != 0 || in_valid || pending_reports.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = $urandom_range(0, 255); while (b == sync_begin || b == sync_end);
    return b;
  endfunction

  function automatic logic [7:0] line_byte();
    case ($urandom_range(0, 4))
      0: return sync_begin;
      1: return sync_end;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // A sync value inside a frame goes out as the sync byte plus one escape marker.
  function automatic void push_stored(input logic [7:0] v);
    if (v == sync_begin || v == sync_end) begin
      line_bytes.push_back(v);
      line_bytes.push_back(plain_byte());
    end else begin
      line_bytes.push_back(v);
    end
  endfunction

  function automatic void push_frame(input int len, input bit corrupt, input int overrun);
    logic [15:0] c;
    logic [7:0] code;
    logic [7:0] d;
    code = plain_byte();
    line_bytes.push_back(sync_begin);
    line_bytes.push_back(sync_begin);
    line_bytes.push_back(code);
    c = crc16_update(seed_value, code);
    for (int i = 0; i < len; i++) begin
      d = line_byte();
      push_stored(d);
      c = crc16_update(c, d);
    end
    c = c ^ final_xor;
    if (corrupt) begin
      c = c ^ (16'h0001 << $urandom_range(0, 15));
    end
    if (high_first) begin
      push_stored(c[15:8]);
      push_stored(c[7:0]);
    end else begin
      push_stored(c[7:0]);
      push_stored(c[15:8]);
    end
    repeat (overrun) line_bytes.push_back(plain_byte());
    line_bytes.push_back(sync_end);
    line_bytes.push_back(sync_end);
  endfunction

  function automatic void push_random_sequence();
    int kind;
    int cap;
    int len;
    cap = (store_cap < STORE_MAX) ? store_cap : STORE_MAX;
    kind = $urandom_range(0, 9);
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
    if (cap >= 2 && len > cap - 2 && $urandom_range(0, 3) != 0) begin
      len = cap - 2;
    end
    if (kind <= 5) begin
      push_frame(len, 1'b0, (cap >= 2 && len == cap - 2) ? $urandom_range(0, 2) : 0);
    end else if (kind == 6) begin
      push_frame(len, 1'b1, 0);
    end else if (kind == 7) begin
      line_bytes.push_back(sync_begin);
      line_bytes.push_back(sync_begin);
      line_bytes.push_back(plain_byte());
      repeat ($urandom_range(0, 6)) push_stored(line_byte());
    end else if (kind == 8) begin
      repeat ($urandom_range(1, 8)) line_bytes.push_back(line_byte());
    end else begin
      line_bytes.push_back(sync_begin);
      line_bytes.push_back(sync_begin);
      line_bytes.push_back(plain_byte());
      repeat ($urandom_range(0, 2)) push_stored(line_byte());
      repeat ($urandom_range(2, 3)) line_bytes.push_back(sync_end);
    end
  endfunction

  initial begin
    int target;
    sync_begin = bsfr_pkg::BEGIN_SYNC_RST;
    sync_end = bsfr_pkg::END_SYNC_RST;
    store_cap = bsfr_pkg::STORE_LIMIT_RST;
    seed_value = bsfr_pkg::CRC_SEED_RST;
    final_xor = bsfr_pkg::CRC_FINAL_XOR_RST;
    high_first = bsfr_pkg::CRC_HIGH_FIRST_RST;
    clear_frame();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Lone end mark outside a frame, then an empty report that leaves the frame open
    // with the end mark still pending across the command byte.
    line_bytes.push_back(8'h12);
    line_bytes.push_back(sync_end);
    line_bytes.push_back(sync_begin);
    line_bytes.push_back(sync_begin);
    line_bytes.push_back(sync_end);
    line_bytes.push_back(sync_end);
    line_bytes.push_back(8'h00);
    line_bytes.push_back(8'hFF);
    line_bytes.push_back(sync_begin);
    line_bytes.push_back(8'h80);
    line_bytes.push_back(sync_begin);
    line_bytes.push_back(sync_begin);
    push_frame(2, 1'b0, 0);
    line_bytes.push_back(8'h33);
    line_bytes.push_back(sync_end);
    line_bytes.push_back(sync_begin);
    line_bytes.push_back(sync_begin);
    wait_idle();

    for (int phase = 1; phase <= 8; phase++) begin
      target = 160;
      case (phase)
        1: load_settings(8'h00, 8'hFF, 11'(LONG_CAP), 16'h0000, 16'hFFFF, 1'b1);
        2: load_settings(8'hFF, 8'h00, 11'd0, 16'hFFFF, 16'h0000, 1'b0);
        3: load_settings(8'h5A, 8'h5A, 11'd8, $urandom, $urandom, $urandom);
        4: load_settings(8'hAA, 8'h55, 11'd3, $urandom, $urandom, $urandom);
        5: load_settings($urandom, $urandom, 11'd1, $urandom, $urandom, $urandom);
        6: load_settings($urandom, $urandom, 11'd2, $urandom, $urandom, $urandom);
        7: load_settings($urandom, $urandom, $urandom_range(4, 60), $urandom, $urandom,
                         $urandom);
        default: load_settings(bsfr_pkg::BEGIN_SYNC_RST, bsfr_pkg::END_SYNC_RST,
                               bsfr_pkg::STORE_LIMIT_RST, bsfr_pkg::CRC_SEED_RST,
                               bsfr_pkg::CRC_FINAL_XOR_RST, bsfr_pkg::CRC_HIGH_FIRST_RST);
      endcase
      if (phase == 1) begin
        // A frame that fills the store up to its limit, with overflow beats before its
        // end marks, sent while the receiver holds off long enough to back up the input.
        @(posedge clk);
        hold_request = 1'b1;
        push_frame(LONG_CAP - 2, 1'b0, 2);
        target = 60;
      end else if (phase == 2) begin
        target = 80;
      end else if (phase == 3) begin
        target = 100;
      end
      target = target + line_bytes.size();
      while (line_bytes.size() < target) push_random_sequence();
      wait_idle();
    end

    repeat (20) @(posedge clk);
    $display("Checked %0d result beats under %0d register settings after reset defaults.",
             report_count, settings_loaded + 1);
    $display("Seen: %0d good, %0d bad CRC, %0d empty, %0d overflow, %0d restarts, %0d data beats.",
             n_good, n_bad, n_empty, n_overflow, n_restart, n_stored);
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("byte_stuffed_frame_receiver_crc16 regression: pass");
    end else begin
      $display("byte_stuffed_frame_receiver_crc16 regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results still expected.", pending_reports.size());
    $display("byte_stuffed_frame_receiver_crc16 regression: fail");
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/bsfr_pkg.sv
design/byte_stuffed_frame_receiver_crc16.sv
tb/byte_stuffed_frame_receiver_crc16_test.sv
